### hdl/u2dc_pkg.sv
// ----------------------------------------------------------------------------
// u2dc_pkg
// Types, character codes and the Latin letter table for the UTF-8 to
// display-capitals converter.
// ----------------------------------------------------------------------------
package u2dc_pkg;

    localparam int RAW_LIMIT_DEF = 63;

    localparam logic [6:0] CH_NUL    = 7'h00;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_APOS   = 7'h27;
    localparam logic [6:0] CH_HYPHEN = 7'h2D;
    localparam logic [6:0] CH_PERIOD = 7'h2E;
    localparam logic [6:0] CH_A      = 7'h41;
    localparam logic [6:0] CH_E      = 7'h45;
    localparam logic [6:0] CH_H      = 7'h48;
    localparam logic [6:0] CH_I      = 7'h49;
    localparam logic [6:0] CH_J      = 7'h4A;
    localparam logic [6:0] CH_O      = 7'h4F;
    localparam logic [6:0] CH_S      = 7'h53;
    localparam logic [6:0] CH_T      = 7'h54;

    localparam logic [10:0] CP_LATIN_LO = 11'h0C0;
    localparam logic [10:0] CP_LATIN_HI = 11'h17F;

    localparam int LATIN_N = 192;

    // Base capitals for U+00C0..U+017F, first entry in the top byte.
    localparam logic [8*LATIN_N-1:0] LATIN_CAPS = {
        "AAAAAA CEEEEIIII", "DNOOOOO OUUUUY  ",
        "AAAAAA CEEEEIIII", "DNOOOOO OUUUUY Y",
        "AAAAAACCCCCCCCDD", "DDEEEEEEEEEEGGGG",
        "GGGGHHHHIIIIIIII", "II  JJKKKLLLLLLL",
        "LLLNNNNNNNNNOOOO", "OO  RRRRRRSSSSSS",
        "SSTTTTTTUUUUUUUU", "UUUUWWYYYZZZZZZS"
    };

    typedef struct packed {
        logic [1:0] n;
        logic [6:0] c0;
        logic [6:0] c1;
    } prod_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } res_t;

    function automatic prod_t translit(input logic [10:0] cp);
        prod_t      p;
        logic [7:0] idx;
        int         pos;
        p   = '{n: 2'd1, c0: CH_SPACE, c1: CH_SPACE};
        idx = 8'(cp - CP_LATIN_LO);
        pos = 8 * (LATIN_N - 1 - int'(idx));
        if (cp == 11'h0C6 || cp == 11'h0E6) begin
            p = '{n: 2'd2, c0: CH_A, c1: CH_E};
        end else if (cp == 11'h0DE || cp == 11'h0FE) begin
            p = '{n: 2'd2, c0: CH_T, c1: CH_H};
        end else if (cp == 11'h0DF) begin
            p = '{n: 2'd2, c0: CH_S, c1: CH_S};
        end else if (cp == 11'h132 || cp == 11'h133) begin
            p = '{n: 2'd2, c0: CH_I, c1: CH_J};
        end else if (cp == 11'h152 || cp == 11'h153) begin
            p = '{n: 2'd2, c0: CH_O, c1: CH_E};
        end else if (cp >= 11'h061 && cp <= 11'h07A) begin
            p.c0 = 7'(cp - 11'd32);
        end else if ((cp >= 11'h041 && cp <= 11'h05A) || (cp >= 11'h030 && cp <= 11'h039)
                     || cp == 11'(CH_PERIOD) || cp == 11'(CH_HYPHEN)
                     || cp == 11'(CH_APOS)) begin
            p.c0 = cp[6:0];
        end else if (cp >= CP_LATIN_LO && cp <= CP_LATIN_HI) begin
            p.c0 = LATIN_CAPS[pos +: 7];
        end
        return p;
    endfunction

endpackage

### hdl/utf8_to_display_capitals_top.sv
// Results are registered: a byte's results are offered from the cycle after it is taken.
// Throughput: one byte per cycle while each byte gives at most one result and m_ready is high;
// a byte that gives two or three results holds the input while the three-entry result register
// drains, one item per cycle while m_ready is high, until its last item is taken.
// Reset: synchronous active-low aresetn clears decode state and drops results.
// ----------------------------------------------------------------------------
// utf8_to_display_capitals_top
// Streaming UTF-8 to display-capitals converter with space collapsing,
// trimming and a limit on produced characters.
// ----------------------------------------------------------------------------
module utf8_to_display_capitals_top #(
    parameter int RAW_LIMIT = u2dc_pkg::RAW_LIMIT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_last
);
    import u2dc_pkg::*;

    localparam int RC_W = $clog2(RAW_LIMIT + 1);
    localparam logic [RC_W-1:0] RAW_MAX = RC_W'(RAW_LIMIT);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LEAD,
        MODE_SKIP
    } mode_t;

    mode_t           mode_reg, mode_next;
    logic [4:0]      lead_reg, lead_next;
    logic            sp_reg, sp_next;
    logic            ea_reg, ea_next;
    logic [RC_W-1:0] rc_reg, rc_next;
    res_t            buf_reg [3];
    res_t            buf_next [3];
    logic [1:0]      cnt_reg, cnt_next;
    logic [1:0]      rd_reg;

    logic            s_acc, m_acc, cont;
    logic            idle_term, term;
    prod_t           idle_prod;
    mode_t           idle_mode;
    logic [4:0]      idle_lead;
    logic [6:0]      plist [3];
    logic [1:0]      pn;
    logic [6:0]      ch;

    assign s_acc      = s_valid && s_ready;
    assign m_acc      = m_valid && m_ready;
    assign s_ready    = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign m_valid    = (cnt_reg != 2'd0);
    assign m_out_char = buf_reg[rd_reg].ch;
    assign m_last     = buf_reg[rd_reg].last;
    assign cont       = (s_in_byte[7:6] == 2'b10);

    always_comb begin
        idle_term = 1'b0;
        idle_prod = '{n: 2'd0, c0: CH_SPACE, c1: CH_SPACE};
        idle_mode = MODE_IDLE;
        idle_lead = 5'd0;
        if (s_in_byte == 8'd0) begin
            idle_term = 1'b1;
        end else if (!s_in_byte[7]) begin
            idle_prod = translit({4'd0, s_in_byte[6:0]});
        end else if (s_in_byte[7:5] == 3'b110) begin
            idle_mode = MODE_LEAD;
            idle_lead = s_in_byte[4:0];
        end else begin
            idle_prod.n = 2'd1;
            idle_mode   = MODE_SKIP;
        end
    end

    always_comb begin
        mode_next = idle_mode;
        lead_next = idle_lead;
        term      = idle_term;
        pn        = idle_prod.n;
        plist[0]  = idle_prod.c0;
        plist[1]  = idle_prod.c1;
        plist[2]  = CH_SPACE;
        unique case (mode_reg)
            MODE_LEAD: begin
                if (cont) begin
                    {pn, plist[0], plist[1]} = translit({lead_reg, s_in_byte[5:0]});
                    mode_next = MODE_IDLE;
                    lead_next = 5'd0;
                    term      = 1'b0;
                end else begin
                    pn       = idle_prod.n + 2'd1;
                    plist[0] = CH_SPACE;
                    plist[1] = idle_prod.c0;
                    plist[2] = idle_prod.c1;
                end
            end
            MODE_SKIP: begin
                if (cont) begin
                    pn        = 2'd0;
                    term      = 1'b0;
                    mode_next = MODE_SKIP;
                    lead_next = lead_reg;
                end
            end
            default: begin end
        endcase
    end

    always_comb begin
        sp_next  = sp_reg;
        ea_next  = ea_reg;
        rc_next  = rc_reg;
        cnt_next = 2'd0;
        ch       = CH_SPACE;
        for (int k = 0; k < 3; k++) begin
            buf_next[k] = '{ch: CH_NUL, last: 1'b0};
        end
        for (int i = 0; i < 3; i++) begin
            ch = plist[i];
            if (i < int'(pn) && rc_next < RAW_MAX) begin
                rc_next = rc_next + RC_W'(1);
                if (ch == CH_SPACE) begin
                    if (ea_next) begin
                        sp_next = 1'b1;
                    end
                end else begin
                    if (sp_next) begin
                        if (cnt_next != 2'd3) begin
                            buf_next[cnt_next] = '{ch: CH_SPACE, last: 1'b0};
                            cnt_next = cnt_next + 2'd1;
                        end
                        sp_next = 1'b0;
                    end
                    if (cnt_next != 2'd3) begin
                        buf_next[cnt_next] = '{ch: ch, last: 1'b0};
                        cnt_next = cnt_next + 2'd1;
                    end
                    ea_next = 1'b1;
                end
            end
        end
        if (term) begin
            if (cnt_next != 2'd3) begin
                buf_next[cnt_next] = '{ch: CH_NUL, last: 1'b1};
                cnt_next = cnt_next + 2'd1;
            end
            sp_next = 1'b0;
            ea_next = 1'b0;
            rc_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            lead_reg <= 5'd0;
            sp_reg   <= 1'b0;
            ea_reg   <= 1'b0;
            rc_reg   <= '0;
            cnt_reg  <= 2'd0;
            rd_reg   <= 2'd0;
        end else if (s_acc) begin
            mode_reg <= term ? MODE_IDLE : mode_next;
            lead_reg <= term ? 5'd0 : lead_next;
            sp_reg   <= sp_next;
            ea_reg   <= ea_next;
            rc_reg   <= rc_next;
            cnt_reg  <= cnt_next;
            rd_reg   <= 2'd0;
        end else if (m_acc) begin
            cnt_reg  <= cnt_reg - 2'd1;
            rd_reg   <= (cnt_reg == 2'd1) ? 2'd0 : rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int k = 0; k < 3; k++) begin
                buf_reg[k] <= buf_next[k];
            end
        end
    end

endmodule

### tb/utf8_to_display_capitals_top_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_display_capitals_top_tb
// Self-checking bench for the UTF-8 to display-capitals converter: a short
// directed string set, then random strings of well-formed and broken UTF-8.
// A predictor tracks decode, space collapsing and the character limit, and
// every output item is checked in order while both sides idle at random.
// ----------------------------------------------------------------------------
module utf8_to_display_capitals_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u2dc_pkg::*;

    typedef enum logic [1:0] {DEC_IDLE, DEC_LEAD, DEC_SKIP} dec_mode_e;

    localparam int         CHAR_LIMIT = RAW_LIMIT_DEF;
    localparam int         MAX_GAP    = 11;
    localparam int         RAND_BYTES = 470;
    localparam int         TAIL_WAIT  = 8;
    localparam logic [7:0] BYTE_END   = 8'h00;

    localparam bit [0:191][7:0] LATIN_TAB = {
        "AAAAAA CEEEEIIII", "DNOOOOO OUUUUY  ",
        "AAAAAA CEEEEIIII", "DNOOOOO OUUUUY Y",
        "AAAAAACCCCCCCCDD", "DDEEEEEEEEEEGGGG",
        "GGGGHHHHIIIIIIII", "II  JJKKKLLLLLLL",
        "LLLNNNNNNNNNOOOO", "OO  RRRRRRSSSSSS",
        "SSTTTTTTUUUUUUUU", "UUUUWWYYYZZZZZZS"
    };

    localparam logic [10:0] LIGATURE_CPS [9] = '{
        11'h0C6, 11'h0E6, 11'h0DE, 11'h0FE, 11'h0DF,
        11'h132, 11'h133, 11'h152, 11'h153
    };

    localparam logic [7:0] DIRECTED_BYTES [26] = '{
        8'h20, "a", "Z", 8'hC3, 8'h86, 8'hC3, 8'h9F, 8'hC5, 8'hBF,
        8'hC0, 8'h80, 8'hC3, "-", 8'h80, 8'hE2, 8'h82, 8'hFF, "9",
        8'h7F, 8'h01, 8'h20, BYTE_END, 8'hC3, BYTE_END,
        8'hF0, BYTE_END
    };

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [6:0] m_out_char;
    logic       m_last;

    // predictor state
    dec_mode_e  dec_mode   = DEC_IDLE;
    logic [4:0] lead_low   = 5'd0;
    bit         owe_space  = 1'b0;
    bit         shown_any  = 1'b0;
    int         char_count = 0;
    int         step_out   = 0;
    res_t       expected_chars [$];

    logic [7:0] pending_bytes [$];
    int         total_bytes    = 0;
    int         bytes_taken    = 0;
    int         chars_seen     = 0;
    int         strings_done   = 0;
    int         strings_capped = 0;
    int         err_count      = 0;
    int         src_gap        = 0;
    int         src_calm       = 0;
    int         sink_stall     = 0;
    int         sink_calm      = 0;

    utf8_to_display_capitals_top #(
        .RAW_LIMIT (CHAR_LIMIT)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void push_char(logic [6:0] ch, logic last);
        if (step_out < 3) begin
            expected_chars.push_back('{ch: ch, last: last});
            step_out++;
        end
    endfunction

    function automatic void count_char(logic [6:0] ch);
        if (char_count < CHAR_LIMIT) begin
            char_count++;
            if (ch == CH_SPACE) begin
                if (shown_any) owe_space = 1'b1;
            end else begin
                if (owe_space) push_char(CH_SPACE, 1'b0);
                owe_space = 1'b0;
                push_char(ch, 1'b0);
                shown_any = 1'b1;
            end
        end
    endfunction

    function automatic void map_code_point(logic [10:0] cp);
        logic [6:0] first;
        logic [6:0] second;
        first  = CH_NUL;
        second = CH_NUL;
        case (cp)
            11'h0C6, 11'h0E6: begin first = CH_A; second = CH_E; end
            11'h0DE, 11'h0FE: begin first = CH_T; second = CH_H; end
            11'h0DF:          begin first = CH_S; second = CH_S; end
            11'h132, 11'h133: begin first = CH_I; second = CH_J; end
            11'h152, 11'h153: begin first = CH_O; second = CH_E; end
            default: ;
        endcase
        if (first != CH_NUL) begin
            count_char(first);
            count_char(second);
        end else if (cp >= 11'h061 && cp <= 11'h07A) begin
            count_char(7'(cp - 11'd32));
        end else if ((cp >= 11'h041 && cp <= 11'h05A) || (cp >= 11'h030 && cp <= 11'h039)
                     || cp == 11'(CH_PERIOD) || cp == 11'(CH_HYPHEN)
                     || cp == 11'(CH_APOS)) begin
            count_char(cp[6:0]);
        end else if (cp >= 11'h0C0 && cp <= 11'h17F) begin
            count_char(LATIN_TAB[cp - 11'h0C0][6:0]);
        end else begin
            count_char(CH_SPACE);
        end
    endfunction

    function automatic void restart_byte(logic [7:0] b);
        if (b == BYTE_END) begin
            push_char(CH_NUL, 1'b1);
            strings_done++;
            if (char_count >= CHAR_LIMIT) strings_capped++;
            dec_mode   = DEC_IDLE;
            lead_low   = 5'd0;
            owe_space  = 1'b0;
            shown_any  = 1'b0;
            char_count = 0;
        end else if (!b[7]) begin
            map_code_point({3'b000, b});
        end else if (b[7:5] == 3'b110) begin
            dec_mode = DEC_LEAD;
            lead_low = b[4:0];
        end else begin
            count_char(CH_SPACE);
            dec_mode = DEC_SKIP;
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        logic cont;
        cont     = (b[7:6] == 2'b10);
        step_out = 0;
        case (dec_mode)
            DEC_LEAD: begin
                dec_mode = DEC_IDLE;
                if (cont) begin
                    map_code_point({lead_low, b[5:0]});
                    lead_low = 5'd0;
                end else begin
                    lead_low = 5'd0;
                    count_char(CH_SPACE);
                    restart_byte(b);
                end
            end
            DEC_SKIP: begin
                if (!cont) begin
                    dec_mode = DEC_IDLE;
                    restart_byte(b);
                end
            end
            default: restart_byte(b);
        endcase
    endfunction

    function automatic int draw_wait(inout int calm);
        int w;
        w = 0;
        if (calm > 0) begin
            calm--;
        end else begin
            if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
            w = $urandom_range(0, MAX_GAP);
        end
        return w;
    endfunction

    function automatic void note_mismatch(string what);
        if (err_count < 10) $display("mismatch at %0t ns: %s", $time, what);
        err_count++;
    endfunction

    function automatic void queue_code_point(logic [10:0] cp);
        pending_bytes.push_back({3'b110, cp[10:6]});
        pending_bytes.push_back({2'b10, cp[5:0]});
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_in_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                predict_byte(s_in_byte);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= pending_bytes.pop_front();
                    src_gap    = draw_wait(src_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    note_mismatch($sformatf("item %0d: char %02h last %0d, none expected",
                                            chars_seen, m_out_char, m_last));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_out_char !== want.ch || m_last !== want.last) begin
                        note_mismatch($sformatf(
                            "item %0d: expected char %02h last %0d, got char %02h last %0d",
                            chars_seen, want.ch, want.last, m_out_char, m_last));
                    end
                end
                sink_stall = draw_wait(sink_calm);
            end else if (sink_stall > 0) begin
                sink_stall--;
            end
            m_ready <= (sink_stall == 0);
        end
    end

    initial begin : stimulus
        int n_tok;
        int n_built;
        int k;
        logic [7:0] lead;
        foreach (DIRECTED_BYTES[i]) pending_bytes.push_back(DIRECTED_BYTES[i]);
        n_built = 0;
        while (pending_bytes.size() < RAND_BYTES) begin
            n_tok = (n_built == 0 || $urandom_range(0, 5) == 0) ? $urandom_range(64, 80)
                                                                 : $urandom_range(1, 20);
            repeat (n_tok) begin
                k = $urandom_range(0, 99);
                if (k < 30) begin
                    pending_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                end else if (k < 45) begin
                    pending_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
                end else if (k < 53) begin
                    pending_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
                end else if (k < 58) begin
                    case ($urandom_range(0, 2))
                        0:       pending_bytes.push_back(8'(CH_PERIOD));
                        1:       pending_bytes.push_back(8'(CH_HYPHEN));
                        default: pending_bytes.push_back(8'(CH_APOS));
                    endcase
                end else if (k < 68) begin
                    repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'(CH_SPACE));
                end else if (k < 73) begin
                    pending_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
                end else if (k < 85) begin
                    lead = $urandom_range(0, 1) ? 8'($urandom_range(8'hC3, 8'hC5))
                                                : 8'($urandom_range(8'hC0, 8'hDF));
                    pending_bytes.push_back(lead);
                    pending_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end else if (k < 89) begin
                    queue_code_point(LIGATURE_CPS[$urandom_range(0, 8)]);
                end else if (k < 94) begin
                    pending_bytes.push_back(8'($urandom_range(8'hE0, 8'hFF)));
                    repeat ($urandom_range(0, 3))
                        pending_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end else if (k < 97) begin
                    repeat ($urandom_range(1, 2))
                        pending_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end else begin
                    pending_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
                end
            end
            pending_bytes.push_back(BYTE_END);
            n_built++;
        end
        total_bytes = pending_bytes.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken < total_bytes || expected_chars.size() > 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        err_count += expected_chars.size();

        $display("%0d bytes in %0d strings, %0d strings cut at the %0d-char limit",
                 bytes_taken, strings_done, strings_capped, CHAR_LIMIT);
        $display("%0d output items checked, %0d mismatches", chars_seen, err_count);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(2_000_000);
        $display("timeout after %0d of %0d bytes", bytes_taken, total_bytes);
        $display("status: fail");
        $finish;
    end

endmodule
